@@ src/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants for the principal-axis rotator
// Holds the fixed-point widths, the angle conversion factors, the CORDIC
// gain, the arctangent table and the record that travels down the cell chain.
// ----------------------------------------------------------------------------
package rpa_pkg;

   // Number of CORDIC iterations, limited to the size of the arctangent table.
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 30;
   localparam int CORDIC_N     = (CORDIC_STEPS < 1) ? 1 :
                                 (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam int STEP_W       = 5;

   // Datapath widths: rotated pair with 8 guard bits, phase with headroom.
   localparam int GUARD_BITS = 8;
   localparam int DW         = 42;
   localparam int ZW         = 34;
   localparam int RW         = DW - GUARD_BITS;

   // Angle to phase factors (2^32 is one full turn).
   localparam int CONV_W     = 42;
   localparam int CONV_SPLIT = 21;
   localparam logic [CONV_W-1:0] DEG_TO_TURN = 42'd48867183457;
   localparam logic [CONV_W-1:0] RAD_TO_TURN = 42'd2799883368761;

   // Gain compensation in Q30, including the finite-iteration tail.
   localparam logic [30:0] GAIN_Q30 =
      31'(64'd652032874 + (64'd434688583 >> (2 * CORDIC_N)));

   // Quarter turn in phase units.
   localparam logic signed [31:0] QUARTER_TURN = 32'sd1073741824;
   localparam logic signed [ZW-1:0] HALF_TURN  = 34'sd2147483648;

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // One record in the rotation chain: rotated pair, residual phase and
   // the untouched axis coordinate.
   typedef struct packed {
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic signed [ZW-1:0] z;
      logic signed [31:0]   keep;
      logic [1:0]           axis;
   } rpa_work_type;

   // atan(2^-i) in units of 2^-32 turn.
   function automatic logic [30:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic [30:0] t;
      case (idx)
         5'd0:    t = 31'd536870912;
         5'd1:    t = 31'd316933406;
         5'd2:    t = 31'd167458907;
         5'd3:    t = 31'd85004756;
         5'd4:    t = 31'd42667331;
         5'd5:    t = 31'd21354465;
         5'd6:    t = 31'd10679838;
         5'd7:    t = 31'd5340245;
         5'd8:    t = 31'd2670163;
         5'd9:    t = 31'd1335087;
         5'd10:   t = 31'd667544;
         5'd11:   t = 31'd333772;
         5'd12:   t = 31'd166886;
         5'd13:   t = 31'd83443;
         5'd14:   t = 31'd41722;
         5'd15:   t = 31'd20861;
         5'd16:   t = 31'd10430;
         5'd17:   t = 31'd5215;
         5'd18:   t = 31'd2608;
         5'd19:   t = 31'd1304;
         5'd20:   t = 31'd652;
         5'd21:   t = 31'd326;
         5'd22:   t = 31'd163;
         5'd23:   t = 31'd81;
         5'd24:   t = 31'd41;
         5'd25:   t = 31'd20;
         5'd26:   t = 31'd10;
         5'd27:   t = 31'd5;
         5'd28:   t = 31'd3;
         5'd29:   t = 31'd1;
         default: t = 31'd0;
      endcase
      return t;
   endfunction

endpackage

@@ src/rpa_front.sv @@
// ----------------------------------------------------------------------------
// rpa_front: phase computation, gain scaling and quadrant fold
// Three registered stages: partial products, phase sum and scaled pair,
// then the fold of the phase into the CORDIC convergence range.
// ----------------------------------------------------------------------------
module rpa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic signed [31:0]   vec_x,
   input  logic signed [31:0]   vec_y,
   input  logic signed [31:0]   vec_z,
   input  logic signed [31:0]   turn_angle,
   input  logic                 angle_in_radians,
   input  logic [1:0]           axis_select,
   output logic                 out_valid,
   output rpa_pkg::rpa_work_type out_work
);
   import rpa_pkg::*;

   // Stage A signals.
   logic [CONV_W-1:0]        conv;
   logic signed [31:0]       va, vb, keep_in;
   logic [1:0]               axis_in;
   logic signed [53:0]       plo_in, phi_in;
   logic signed [63:0]       ga_in, gb_in;
   logic                     va_ff;
   logic signed [53:0]       plo_ff, phi_ff;
   logic signed [63:0]       ga_ff, gb_ff;
   logic signed [31:0]       keep_a_ff;
   logic [1:0]               axis_a_ff;

   // Stage B signals.
   logic signed [63:0]       phase_sum, ra_sum, rb_sum;
   logic                     vb_ff;
   logic signed [31:0]       z_ff;
   logic signed [DW-1:0]     a_ff, b_ff;
   logic signed [31:0]       keep_b_ff;
   logic [1:0]               axis_b_ff;

   // Stage C signals.
   rpa_work_type             work_in, work_ff;
   logic                     vc_ff;

   // Pick the rotated pair and the pass-through coordinate by axis.
   always_comb begin
      case (axis_select)
         AXIS_Y: begin
            va      = vec_z;
            vb      = vec_x;
            keep_in = vec_y;
            axis_in = AXIS_Y;
         end
         AXIS_Z: begin
            va      = vec_x;
            vb      = vec_y;
            keep_in = vec_z;
            axis_in = AXIS_Z;
         end
         default: begin
            va      = vec_y;
            vb      = vec_z;
            keep_in = vec_x;
            axis_in = AXIS_X;
         end
      endcase
   end

   // Split the conversion factor so each product stays near 32 by 21 bits.
   assign conv   = angle_in_radians ? RAD_TO_TURN : DEG_TO_TURN;
   assign plo_in = turn_angle * $signed({1'b0, conv[CONV_SPLIT-1:0]});
   assign phi_in = turn_angle * $signed({1'b0, conv[CONV_W-1:CONV_SPLIT]});
   assign ga_in  = va * $signed({1'b0, GAIN_Q30});
   assign gb_in  = vb * $signed({1'b0, GAIN_Q30});

   // Stage A registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         ga_ff     <= ga_in;
         gb_ff     <= gb_in;
         keep_a_ff <= keep_in;
         axis_a_ff <= axis_in;
      end
   end

   // Recombine the partial products; the 64-bit wrap reduces modulo one turn.
   assign phase_sum = (64'(phi_ff) <<< CONV_SPLIT) + 64'(plo_ff) + 64'sh80000000;
   assign ra_sum    = ga_ff + 64'sh200000;
   assign rb_sum    = gb_ff + 64'sh200000;

   // Stage B registers: phase and scaled pair with guard bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff      <= phase_sum[63:32];
         a_ff      <= ra_sum[63:22];
         b_ff      <= rb_sum[63:22];
         keep_b_ff <= keep_a_ff;
         axis_b_ff <= axis_a_ff;
      end
   end

   // Fold phases beyond a quarter turn by a half turn and negate the pair.
   always_comb begin
      work_in.keep = keep_b_ff;
      work_in.axis = axis_b_ff;
      if (z_ff > QUARTER_TURN) begin
         work_in.z = ZW'(z_ff) - HALF_TURN;
         work_in.a = -a_ff;
         work_in.b = -b_ff;
      end else if (z_ff < -QUARTER_TURN) begin
         work_in.z = ZW'(z_ff) + HALF_TURN;
         work_in.a = -a_ff;
         work_in.b = -b_ff;
      end else begin
         work_in.z = ZW'(z_ff);
         work_in.a = a_ff;
         work_in.b = b_ff;
      end
   end

   // Stage C registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (advance) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_work  = work_ff;

endmodule

@@ src/rpa_cell.sv @@
// ----------------------------------------------------------------------------
// rpa_cell: one CORDIC micro-rotation
// Rotates the pair by plus or minus atan(2^-i) according to the sign of the
// residual phase and hands the result to the next cell.
// ----------------------------------------------------------------------------
module rpa_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [rpa_pkg::STEP_W-1:0]     step_idx,
   input  logic                           in_valid,
   input  rpa_pkg::rpa_work_type          in_work,
   output logic                           out_valid,
   output rpa_pkg::rpa_work_type          out_work
);
   import rpa_pkg::*;

   logic signed [DW-1:0] da, db;
   logic signed [ZW-1:0] dz;
   rpa_work_type         work_in, work_ff;
   logic                 valid_ff;

   // Arithmetic shifts round toward minus infinity.
   assign da = in_work.b >>> step_idx;
   assign db = in_work.a >>> step_idx;
   assign dz = $signed(ZW'(atan_turn(step_idx)));

   // Direction follows the sign of the residual phase.
   always_comb begin
      work_in = in_work;
      if (!in_work.z[ZW-1]) begin
         work_in.a = in_work.a - da;
         work_in.b = in_work.b + db;
         work_in.z = in_work.z - dz;
      end else begin
         work_in.a = in_work.a + da;
         work_in.b = in_work.b - db;
         work_in.z = in_work.z + dz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

@@ src/rpa_back.sv @@
// ----------------------------------------------------------------------------
// rpa_back: rounding, saturation and output register
// Drops the guard bits with rounding, clamps to Q16.16 range, places the
// pair back around the axis coordinate and holds the result transaction.
// ----------------------------------------------------------------------------
module rpa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  rpa_pkg::rpa_work_type in_work,
   output logic                  out_valid,
   output logic signed [31:0]    out_x,
   output logic signed [31:0]    out_y,
   output logic signed [31:0]    out_z,
   output logic                  clipped
);
   import rpa_pkg::*;

   logic signed [DW-1:0] sum_a, sum_b;
   logic signed [RW-1:0] ra, rb;
   logic signed [31:0]   sa, sb;
   logic                 clip_a, clip_b;
   logic signed [31:0]   x_in, y_in, z_in;
   logic signed [31:0]   x_ff, y_ff, z_ff;
   logic                 clip_ff;
   logic                 valid_ff;

   // Round to nearest at the guard bit boundary.
   assign sum_a = in_work.a + DW'(128);
   assign sum_b = in_work.b + DW'(128);
   assign ra    = sum_a[DW-1:GUARD_BITS];
   assign rb    = sum_b[DW-1:GUARD_BITS];

   // Clamp when the bits above the 32-bit sign disagree.
   always_comb begin
      clip_a = (ra[RW-1:31] != {(RW-31){1'b0}}) && (ra[RW-1:31] != {(RW-31){1'b1}});
      clip_b = (rb[RW-1:31] != {(RW-31){1'b0}}) && (rb[RW-1:31] != {(RW-31){1'b1}});
      if (clip_a) begin
         sa = ra[RW-1] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         sa = ra[31:0];
      end
      if (clip_b) begin
         sb = rb[RW-1] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         sb = rb[31:0];
      end
   end

   // Put the rotated pair back in place around the axis coordinate.
   always_comb begin
      case (in_work.axis)
         AXIS_Y: begin
            x_in = sb;
            y_in = in_work.keep;
            z_in = sa;
         end
         AXIS_Z: begin
            x_in = sa;
            y_in = sb;
            z_in = in_work.keep;
         end
         default: begin
            x_in = in_work.keep;
            y_in = sa;
            z_in = sb;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         clip_ff <= clip_a | clip_b;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign clipped   = clip_ff;

endmodule

@@ src/rotate_about_principal_axis_core.sv @@
// ----------------------------------------------------------------------------
// rotate_about_principal_axis_core: CORDIC rotation about the x, y or z axis
// The path runs through three front stages, one stage per CORDIC cell and
// the output register.
// Throughput is one transaction per cycle; the whole chain advances together
// and holds only while a finished result waits and the sink is not ready.
// Synchronous active-high reset clears all valid flags; data is not reset.
// ----------------------------------------------------------------------------
module rotate_about_principal_axis_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // vec_x, vec_y, vec_z, turn_angle
   input  logic [2:0]    req_tuser,   // angle_in_radians, axis_select
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // out_x, out_y, out_z
   output logic [0:0]    rsp_tuser    // clipped
);
   import rpa_pkg::*;

   logic               advance;
   logic               chain_valid [0:CORDIC_N];
   rpa_work_type       chain_work  [0:CORDIC_N];
   logic signed [31:0] out_x, out_y, out_z;
   logic               clipped;

   // The chain moves whenever the output register is empty or being drained.
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   // Phase, scaling and quadrant fold.
   rpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (req_tvalid),
      .vec_x            ($signed(req_tdata[31:0])),
      .vec_y            ($signed(req_tdata[63:32])),
      .vec_z            ($signed(req_tdata[95:64])),
      .turn_angle       ($signed(req_tdata[127:96])),
      .angle_in_radians (req_tuser[0]),
      .axis_select      (req_tuser[2:1]),
      .out_valid        (chain_valid[0]),
      .out_work         (chain_work[0])
   );

   // Row of micro-rotation cells, one per iteration.
   for (genvar k = 0; k < CORDIC_N; k++) begin : g_cell
      rpa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step_idx  (STEP_W'(k)),
         .in_valid  (chain_valid[k]),
         .in_work   (chain_work[k]),
         .out_valid (chain_valid[k+1]),
         .out_work  (chain_work[k+1])
      );
   end

   // Rounding, saturation and result register.
   rpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chain_valid[CORDIC_N]),
      .in_work   (chain_work[CORDIC_N]),
      .out_valid (rsp_tvalid),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_z     (out_z),
      .clipped   (clipped)
   );

   assign rsp_tdata = {out_z, out_y, out_x};
   assign rsp_tuser = clipped;

endmodule
